@@ hdl/blr_pkg.sv @@
// Shared types and constants of the Bresenham line rasterizer.
`default_nettype none

package blr_pkg;

  // Coordinate, configuration and payload widths
  localparam int unsigned COORD_W = 6;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ERR_W = COORD_W + 3;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CANVAS_SIZE_DFLT = 64;

  // Register indexes (byte address divided by four)
  localparam logic [1:0] REG_CANVAS_WIDTH = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DRAW_COLOR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } blr_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
  } blr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
  } blr_sts_t;

endpackage

`default_nettype wire

@@ hdl/blr_ctrl.sv @@
// Controller state machine: request acceptance, stepping and output valid.
`default_nettype none

module blr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output blr_pkg::blr_cmd_t  cmd,
  input  wire blr_pkg::blr_sts_t sts
);
  import blr_pkg::*;

  blr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load = in_tvalid;
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = slot_free;
        if (slot_free && sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the output until taken; refill on every step
  always_comb begin
    if (cmd.step) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/blr_dpath.sv @@
// Datapath: line setup, Bresenham stepping and the output register.
`default_nettype none

module blr_dpath (
  input  wire logic                            clk,
  input  wire blr_pkg::blr_cmd_t               cmd,
  output blr_pkg::blr_sts_t                    sts,
  input  wire logic [blr_pkg::COORD_W-1:0]     start_x,
  input  wire logic [blr_pkg::COORD_W-1:0]     start_y,
  input  wire logic [blr_pkg::COORD_W-1:0]     end_x,
  input  wire logic [blr_pkg::COORD_W-1:0]     end_y,
  input  wire logic [blr_pkg::SIZE_W-1:0]      canvas_width,
  input  wire logic [blr_pkg::SIZE_W-1:0]      canvas_height,
  input  wire logic [blr_pkg::COLOR_W-1:0]     draw_color,
  output logic [blr_pkg::COORD_W-1:0]          pixel_x,
  output logic [blr_pkg::COORD_W-1:0]          pixel_y,
  output logic                                 inside_res,
  output logic [blr_pkg::COLOR_W-1:0]          pixel_color,
  output logic                                 last
);
  import blr_pkg::*;

  // Setup values of a new line
  logic                      neg_x, neg_y, ymajor;
  logic [COORD_W-1:0]        adx, ady, dmaj, dmin;
  logic signed [ERR_W-1:0]   err_init, inc_pos_init, inc_neg_init;

  // Walk state
  logic [COORD_W-1:0]        x_r, x_nxt, y_r, y_nxt, cnt_r, cnt_nxt;
  logic                      neg_x_r, neg_y_r, ymajor_r;
  logic signed [ERR_W-1:0]   err_r, err_nxt, inc_pos_r, inc_neg_r;
  logic                      adv_x, adv_y, err_neg;

  // Mirror the segment so it runs increasing; pick the major axis
  always_comb begin
    neg_x = start_x > end_x;
    neg_y = start_y > end_y;
    adx = neg_x ? (start_x - end_x) : (end_x - start_x);
    ady = neg_y ? (start_y - end_y) : (end_y - start_y);
    ymajor = adx < ady;
    dmaj = ymajor ? ady : adx;
    dmin = ymajor ? adx : ady;
    inc_pos_init = $signed({2'b00, dmin, 1'b0});
    inc_neg_init = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
    err_init = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  end

  // Advance one major-axis step; the minor axis follows when the error is not negative
  always_comb begin
    err_neg = err_r[ERR_W-1];
    adv_x = !ymajor_r || !err_neg;
    adv_y = ymajor_r || !err_neg;
    x_nxt = adv_x ? (neg_x_r ? x_r - 1'b1 : x_r + 1'b1) : x_r;
    y_nxt = adv_y ? (neg_y_r ? y_r - 1'b1 : y_r + 1'b1) : y_r;
    err_nxt = err_neg ? err_r + inc_pos_r : err_r + inc_neg_r;
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= start_x;
      y_r <= start_y;
      cnt_r <= dmaj;
      neg_x_r <= neg_x;
      neg_y_r <= neg_y;
      ymajor_r <= ymajor;
      err_r <= err_init;
      inc_pos_r <= inc_pos_init;
      inc_neg_r <= inc_neg_init;
    end else if (cmd.step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  assign sts.last = (cnt_r == '0);

  // Capture the current pixel into the output register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x <= x_r;
      pixel_y <= y_r;
      inside_res <= ({1'b0, x_r} < canvas_width) && ({1'b0, y_r} < canvas_height);
      pixel_color <= draw_color;
      last <= sts.last;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bresenham_line_rasterizer_core.sv @@
// Top level of the Bresenham line rasterizer: configuration registers and stream ports.
`default_nettype none

// Takes one line segment per request on the in_ stream and emits every pixel of the
// Bresenham line from start to end point on the out_ stream, one pixel per step along
// the major axis, the end point marked by out_tlast. Each pixel carries the draw color
// and a flag that tells whether it lies inside the configured canvas. A line with major
// extent d = max(|dx|,|dy|) gives d+1 pixels. A request is accepted while idle; the
// datapath then steps once per pixel, each step waiting while the output register
// holds an untaken pixel. The next request is taken after the end point's step, while
// that pixel may still wait in the output register. Configuration must be written
// through the cfg_ port while no line is in progress; the block does not enforce it.
module bresenham_line_rasterizer_core #(
  parameter int unsigned CANVAS_SIZE = blr_pkg::CANVAS_SIZE_DFLT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
  input  wire logic [blr_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // pixel_x [5:0], pixel_y [11:6], pixel_color [35:12], zero [39:36]
  output logic [blr_pkg::OUT_DATA_W-1:0]         out_tdata,
  // inside_res [0]
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [blr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [blr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [blr_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);
  import blr_pkg::*;

  logic [SIZE_W-1:0]  canvas_width_r, canvas_height_r;
  logic [COLOR_W-1:0] draw_color_r;
  logic [1:0]         reg_idx;
  logic               cfg_wr;
  blr_cmd_t           cmd;
  blr_sts_t           sts;
  logic [COORD_W-1:0] pixel_x, pixel_y;
  logic [COLOR_W-1:0] pixel_color;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[3:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r <= SIZE_W'(CANVAS_SIZE);
      canvas_height_r <= SIZE_W'(CANVAS_SIZE);
      draw_color_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CANVAS_WIDTH:  canvas_width_r <= cfg_pwdata[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_pwdata[SIZE_W-1:0];
        REG_DRAW_COLOR:    draw_color_r <= cfg_pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_CANVAS_WIDTH:  cfg_prdata = {{(CFG_DATA_W-SIZE_W){1'b0}}, canvas_width_r};
      REG_CANVAS_HEIGHT: cfg_prdata = {{(CFG_DATA_W-SIZE_W){1'b0}}, canvas_height_r};
      REG_DRAW_COLOR:    cfg_prdata = {{(CFG_DATA_W-COLOR_W){1'b0}}, draw_color_r};
      default:           cfg_prdata = '0;
    endcase
  end

  blr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  blr_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .start_x       (in_tdata[5:0]),
    .start_y       (in_tdata[11:6]),
    .end_x         (in_tdata[17:12]),
    .end_y         (in_tdata[23:18]),
    .canvas_width  (canvas_width_r),
    .canvas_height (canvas_height_r),
    .draw_color    (draw_color_r),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .inside_res    (out_tuser),
    .pixel_color   (pixel_color),
    .last          (out_tlast)
  );

  assign out_tdata = {4'b0000, pixel_color, pixel_y, pixel_x};

endmodule

`default_nettype wire

@@ hdl/blr_checker.sv @@
// Port-level checker of the line rasterizer and its bind to the top level.
`default_nettype none

module blr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // Hold a stalled pixel unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output pixel changed");

  // Clear the output after reset
  a_out_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Take no new request while a line is being walked
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken during a line");

  // Follow a non-final pixel with the next one without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a line");

endmodule

bind bresenham_line_rasterizer_core blr_checker u_blr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
